// File: rtl/core/tar_idx_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tar_idx_pkg
// Types and constants shared by the tar archive entry indexer and its checker.
// ----------------------------------------------------------------------------
package tar_idx_pkg;

  localparam int BLOCK_BYTES     = 512;
  localparam int BIB_W           = $clog2(BLOCK_BYTES);
  localparam int SIZE_W          = 36;
  localparam int BLK_W           = SIZE_W + 1 - BIB_W;
  localparam int OUT_OFF_W       = 48;
  localparam int OFFSET_BITS_DEF = 48;
  localparam int CFG_W           = 16;

  localparam logic [BIB_W-1:0] SIZE_FIRST = BIB_W'(124);
  localparam logic [BIB_W-1:0] SIZE_LAST  = BIB_W'(135);
  localparam logic [BIB_W-1:0] TYPE_POS   = BIB_W'(156);
  localparam logic [BIB_W-1:0] LAST_BYTE  = BIB_W'(BLOCK_BYTES - 1);

  localparam logic [7:0] LONG_NAME_TYPE = 8'h4C;
  localparam logic [7:0] CH_SPACE       = 8'h20;
  localparam logic [7:0] CH_TAB         = 8'h09;
  localparam logic [7:0] CH_CR          = 8'h0D;
  localparam logic [7:0] CH_PLUS        = 8'h2B;
  localparam logic [7:0] CH_MINUS       = 8'h2D;
  localparam logic [7:0] CH_ZERO        = 8'h30;
  localparam logic [7:0] CH_SEVEN       = 8'h37;

  localparam logic [CFG_W-1:0] MAX_LONG_RESET = CFG_W'(1023);

  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_EOS  = 1'b1;

  localparam logic [1:0] KIND_ENTRY     = 2'd0;
  localparam logic [1:0] KIND_ZERO_END  = 2'd1;
  localparam logic [1:0] KIND_STREAM_END = 2'd2;
  localparam logic [1:0] KIND_ERROR     = 2'd3;

  localparam logic [2:0] ERR_BAD_LONG_SIZE = 3'd0;
  localparam logic [2:0] ERR_LONG_CUT      = 3'd1;
  localparam logic [2:0] ERR_AFTER_LONG_CUT = 3'd2;
  localparam logic [2:0] ERR_BAD_SIZE      = 3'd3;
  localparam logic [2:0] ERR_CUT_BLOCK     = 3'd4;
  localparam logic [2:0] ERR_NONE          = 3'd0;

  typedef enum logic [4:0] {
    PH_HEADER     = 5'b00001,
    PH_LONG_DATA  = 5'b00010,
    PH_AFTER_LONG = 5'b00100,
    PH_SKIP       = 5'b01000,
    PH_DONE       = 5'b10000
  } phase_t;

  typedef enum logic [7:0] {
    PM_WS        = 8'b0000_0001,
    PM_PLUS      = 8'b0000_0010,
    PM_MINUS     = 8'b0000_0100,
    PM_DIG_POS   = 8'b0000_1000,
    PM_DIG_NEG   = 8'b0001_0000,
    PM_STOP_NONE = 8'b0010_0000,
    PM_STOP_POS  = 8'b0100_0000,
    PM_STOP_NEG  = 8'b1000_0000
  } parse_mode_t;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [2:0]           error_code;
    logic [OUT_OFF_W-1:0] data_offset;
    logic [SIZE_W-1:0]    file_size;
    logic                 long_name_used;
  } out_word_t;

endpackage
`default_nettype wire

// File: rtl/core/tar_archive_entry_indexer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tar_archive_entry_indexer
// Scans a tar archive byte stream and reports one word per entry, end or error event.
// ----------------------------------------------------------------------------
// usage
//   in_*  : one archive byte (or an end of stream marker) per accepted word,
//           taken when in_valid is high and in_stall is low
//   out_* : entry, end or error words, taken when out_valid is high and
//           out_stall is low
//   cfg_* : write of max_long_name_bytes, cfg_ready is always high; write only
//           while the block is idle
// throughput : one input word per cycle while in_stall is low, set by the single
//              registered pass from the parser state to the output register
// result     : the word that an accepted input word causes is registered in the
//              output register, or in the skid stage while the output stalls
// stall      : a two-entry output register and skid stage; in_stall rises
//              only once both hold a word, so one more result is absorbed
//              after the receiver stalls
// reset      : rst_n is synchronous; it clears the parser to the start of an
//              archive, empties the output stages and sets the register to
//              1023
// after an end or error word all further input is taken and dropped
// ----------------------------------------------------------------------------
module tar_archive_entry_indexer #(
  parameter int OFFSET_BITS = tar_idx_pkg::OFFSET_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire tar_idx_pkg::in_word_t         in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output tar_idx_pkg::out_word_t             out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [tar_idx_pkg::CFG_W-1:0] cfg_data
);

  localparam int BIB_W  = tar_idx_pkg::BIB_W;
  localparam int SIZE_W = tar_idx_pkg::SIZE_W;
  localparam int BLK_W  = tar_idx_pkg::BLK_W;
  localparam int OOW    = tar_idx_pkg::OUT_OFF_W;
  localparam int CFG_W  = tar_idx_pkg::CFG_W;

  tar_idx_pkg::phase_t      phase_r, phase_nxt;
  tar_idx_pkg::parse_mode_t pm_r, pm_nxt, pm_base;
  logic [BIB_W-1:0]         bib_r, bib_nxt;
  logic                     az_r, az_nxt;
  logic                     zhs_r, zhs_nxt;
  logic [7:0]               type_r, type_nxt;
  logic [SIZE_W-1:0]        acc_r, acc_nxt, acc_base;
  logic [BLK_W-1:0]         blocks_r, blocks_nxt, blocks_calc, blocks_dec;
  logic [OFFSET_BITS-1:0]   off_r, off_nxt;
  logic [CFG_W-1:0]         max_long_r;

  logic                     out_valid_r, skid_valid_r;
  tar_idx_pkg::out_word_t   out_r, skid_r, res;
  logic                     res_hit, accept, take_out;

  logic [7:0]               b;
  logic                     is_oct, is_ws, in_field, last, size_ok;
  logic [2:0]               dig;
  logic [SIZE_W:0]          size_round;
  logic [OFFSET_BITS+OOW-1:0] off_wide;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign accept    = in_valid && !in_stall;
  assign take_out  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign b        = in_data.data_byte;
  assign is_oct   = (b >= tar_idx_pkg::CH_ZERO) && (b <= tar_idx_pkg::CH_SEVEN);
  assign dig      = b[2:0];
  assign is_ws    = (b == tar_idx_pkg::CH_SPACE) ||
                    ((b >= tar_idx_pkg::CH_TAB) && (b <= tar_idx_pkg::CH_CR));
  assign in_field = (bib_r >= tar_idx_pkg::SIZE_FIRST) && (bib_r <= tar_idx_pkg::SIZE_LAST);
  assign last     = (bib_r == tar_idx_pkg::LAST_BYTE);
  assign size_ok  = (pm_nxt == tar_idx_pkg::PM_DIG_POS) || (pm_nxt == tar_idx_pkg::PM_STOP_POS);

  assign size_round  = {1'b0, acc_nxt} + (SIZE_W + 1)'(tar_idx_pkg::BLOCK_BYTES - 1);
  assign blocks_calc = size_round[SIZE_W:BIB_W];
  assign blocks_dec  = blocks_r - BLK_W'(1);
  assign off_wide    = {{OOW{1'b0}}, off_nxt};

  always_comb begin
    phase_nxt  = phase_r;
    pm_nxt     = pm_r;
    bib_nxt    = bib_r;
    az_nxt     = az_r;
    zhs_nxt    = zhs_r;
    type_nxt   = type_r;
    acc_nxt    = acc_r;
    blocks_nxt = blocks_r;
    off_nxt    = off_r;
    pm_base    = pm_r;
    acc_base   = acc_r;
    res_hit    = 1'b0;
    res.kind           = tar_idx_pkg::KIND_ENTRY;
    res.error_code     = tar_idx_pkg::ERR_NONE;
    res.data_offset    = '0;
    res.file_size      = '0;
    res.long_name_used = 1'b0;

    if (phase_r != tar_idx_pkg::PH_DONE) begin
      if (in_data.func == tar_idx_pkg::FUNC_EOS) begin
        res_hit   = 1'b1;
        phase_nxt = tar_idx_pkg::PH_DONE;
        priority if (phase_r == tar_idx_pkg::PH_LONG_DATA) begin
          res.kind       = tar_idx_pkg::KIND_ERROR;
          res.error_code = tar_idx_pkg::ERR_LONG_CUT;
        end else if (phase_r == tar_idx_pkg::PH_AFTER_LONG) begin
          res.kind       = tar_idx_pkg::KIND_ERROR;
          res.error_code = tar_idx_pkg::ERR_AFTER_LONG_CUT;
        end else if (phase_r == tar_idx_pkg::PH_HEADER && bib_r != '0) begin
          res.kind       = tar_idx_pkg::KIND_ERROR;
          res.error_code = tar_idx_pkg::ERR_CUT_BLOCK;
        end else begin
          res.kind       = tar_idx_pkg::KIND_STREAM_END;
        end
      end else begin
        off_nxt = off_r + OFFSET_BITS'(1);

        if (phase_r == tar_idx_pkg::PH_HEADER || phase_r == tar_idx_pkg::PH_AFTER_LONG) begin
          if (bib_r == '0) begin
            az_nxt   = 1'b1;
            acc_base = '0;
            pm_base  = tar_idx_pkg::PM_WS;
          end
          acc_nxt = acc_base;
          pm_nxt  = pm_base;
          if (b != 8'h00) begin
            az_nxt = 1'b0;
          end
          if (in_field) begin
            unique case (pm_base)
              tar_idx_pkg::PM_WS: begin
                priority if (is_ws) begin
                  pm_nxt = pm_base;
                end else if (b == tar_idx_pkg::CH_PLUS) begin
                  pm_nxt = tar_idx_pkg::PM_PLUS;
                end else if (b == tar_idx_pkg::CH_MINUS) begin
                  pm_nxt = tar_idx_pkg::PM_MINUS;
                end else if (is_oct) begin
                  acc_nxt = SIZE_W'(dig);
                  pm_nxt  = tar_idx_pkg::PM_DIG_POS;
                end else begin
                  pm_nxt = tar_idx_pkg::PM_STOP_NONE;
                end
              end
              tar_idx_pkg::PM_PLUS, tar_idx_pkg::PM_MINUS: begin
                if (is_oct) begin
                  acc_nxt = SIZE_W'(dig);
                  pm_nxt  = (pm_base == tar_idx_pkg::PM_PLUS) ? tar_idx_pkg::PM_DIG_POS
                                                                : tar_idx_pkg::PM_DIG_NEG;
                end else begin
                  pm_nxt = tar_idx_pkg::PM_STOP_NONE;
                end
              end
              tar_idx_pkg::PM_DIG_POS, tar_idx_pkg::PM_DIG_NEG: begin
                if (is_oct) begin
                  acc_nxt = {acc_base[SIZE_W-4:0], dig};
                end else begin
                  pm_nxt = (pm_base == tar_idx_pkg::PM_DIG_POS) ? tar_idx_pkg::PM_STOP_POS
                                                                  : tar_idx_pkg::PM_STOP_NEG;
                end
              end
              default: begin
                pm_nxt = pm_base;
              end
            endcase
          end
          if (bib_r == tar_idx_pkg::TYPE_POS) begin
            type_nxt = b;
          end
        end

        bib_nxt = last ? '0 : bib_r + BIB_W'(1);

        if (last) begin
          unique case (phase_r)
            tar_idx_pkg::PH_HEADER: begin
              if (az_nxt) begin
                if (zhs_r) begin
                  res_hit   = 1'b1;
                  res.kind  = tar_idx_pkg::KIND_ZERO_END;
                  phase_nxt = tar_idx_pkg::PH_DONE;
                end else begin
                  zhs_nxt = 1'b1;
                end
              end else begin
                zhs_nxt = 1'b0;
                if (type_nxt == tar_idx_pkg::LONG_NAME_TYPE) begin
                  if (!size_ok || acc_nxt == '0 ||
                      acc_nxt >= SIZE_W'(max_long_r)) begin
                    res_hit        = 1'b1;
                    res.kind       = tar_idx_pkg::KIND_ERROR;
                    res.error_code = tar_idx_pkg::ERR_BAD_LONG_SIZE;
                    phase_nxt      = tar_idx_pkg::PH_DONE;
                  end else begin
                    blocks_nxt = blocks_calc;
                    phase_nxt  = tar_idx_pkg::PH_LONG_DATA;
                  end
                end else begin
                  res_hit = 1'b1;
                  if (!size_ok) begin
                    res.kind       = tar_idx_pkg::KIND_ERROR;
                    res.error_code = tar_idx_pkg::ERR_BAD_SIZE;
                    phase_nxt      = tar_idx_pkg::PH_DONE;
                  end else begin
                    res.file_size = acc_nxt;
                    blocks_nxt    = blocks_calc;
                    phase_nxt     = (blocks_calc != '0) ? tar_idx_pkg::PH_SKIP
                                                        : tar_idx_pkg::PH_HEADER;
                  end
                end
              end
            end
            tar_idx_pkg::PH_AFTER_LONG: begin
              res_hit = 1'b1;
              if (!size_ok) begin
                res.kind       = tar_idx_pkg::KIND_ERROR;
                res.error_code = tar_idx_pkg::ERR_BAD_SIZE;
                phase_nxt      = tar_idx_pkg::PH_DONE;
              end else begin
                res.file_size      = acc_nxt;
                res.long_name_used = 1'b1;
                blocks_nxt         = blocks_calc;
                phase_nxt          = (blocks_calc != '0) ? tar_idx_pkg::PH_SKIP
                                                         : tar_idx_pkg::PH_HEADER;
              end
            end
            tar_idx_pkg::PH_LONG_DATA: begin
              blocks_nxt = blocks_dec;
              if (blocks_dec == '0) begin
                phase_nxt = tar_idx_pkg::PH_AFTER_LONG;
              end
            end
            tar_idx_pkg::PH_SKIP: begin
              blocks_nxt = blocks_dec;
              if (blocks_dec == '0) begin
                phase_nxt = tar_idx_pkg::PH_HEADER;
              end
            end
            default: begin
              phase_nxt = phase_r;
            end
          endcase
        end
      end
    end
    res.data_offset = off_wide[OOW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= tar_idx_pkg::PH_HEADER;
      pm_r       <= tar_idx_pkg::PM_WS;
      bib_r      <= '0;
      az_r       <= 1'b1;
      zhs_r      <= 1'b0;
      type_r     <= '0;
      acc_r      <= '0;
      blocks_r   <= '0;
      off_r      <= '0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      pm_r       <= pm_nxt;
      bib_r      <= bib_nxt;
      az_r       <= az_nxt;
      zhs_r      <= zhs_nxt;
      type_r     <= type_nxt;
      acc_r      <= acc_nxt;
      blocks_r   <= blocks_nxt;
      off_r      <= off_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_long_r <= tar_idx_pkg::MAX_LONG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_long_r <= cfg_data;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (take_out || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= accept && res_hit;
      end
    end else if (accept && res_hit) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take_out || !out_valid_r) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else begin
        out_r <= res;
      end
    end else if (accept && res_hit) begin
      skid_r <= res;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/tar_idx_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tar_idx_checker
// Port-level checks on the tar archive entry indexer, bound into the indexer module.
// ----------------------------------------------------------------------------
module tar_idx_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire tar_idx_pkg::in_word_t         in_data,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire tar_idx_pkg::out_word_t        out_data
);

  // a held output word stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output word dropped or changed while stalled");

  // a new output word needs an accepted input word in the cycle before
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(out_valid) |-> $past(in_valid && !in_stall))
    else $error("output word without an accepted input word");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != tar_idx_pkg::KIND_ERROR |->
      out_data.error_code == tar_idx_pkg::ERR_NONE)
    else $error("error code set on a non-error word");

  a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != tar_idx_pkg::KIND_ENTRY |->
      out_data.file_size == '0 && !out_data.long_name_used)
    else $error("size or long-name flag set on a non-entry word");

endmodule

bind tar_archive_entry_indexer tar_idx_checker u_tar_idx_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

// File: dv/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tar archive entry indexer.
// Builds tar byte streams (plain entries, long-name runs, lone zero blocks)
// and predicts every entry, end and error word with an in-bench model of the
// header parser. Output words are checked field by field in arrival order.
// Idling on both sides is varied between phases, the output is held off for a
// long stretch once, and each run ends the archive in one randomly chosen way.
// ----------------------------------------------------------------------------
module tb;
  import tar_idx_pkg::*;

  localparam int SIZE_LEN       = SIZE_LAST - SIZE_FIRST + 1;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 3000;

  typedef enum int {
    END_TWO_ZERO,
    END_AT_BOUNDARY,
    END_IN_DATA,
    END_BAD_LONG,
    END_LONG_CUT,
    END_AFTER_LONG_CUT,
    END_BAD_SIZE,
    END_CUT_HEADER
  } end_case_t;

  logic            clk;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  logic            in_stall;
  in_word_t        in_data   = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  out_word_t       out_data;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;

  // archive tracker state
  logic [BIB_W-1:0]     pos        = '0;
  logic                 blk_zero   = 1'b1;
  logic                 zero_seen  = 1'b0;
  phase_t               ph         = PH_HEADER;
  logic [7:0]           type_b     = '0;
  logic [SIZE_W-1:0]    size_acc   = '0;
  parse_mode_t          pmode      = PM_WS;
  logic [BLK_W-1:0]     blk_left   = '0;
  logic [OUT_OFF_W-1:0] offset     = '0;
  logic [CFG_W-1:0]     long_limit = MAX_LONG_RESET;

  out_word_t  entries_due[$];
  int         mismatches   = 0;
  int         stuck_cycles = 0;
  int         send_idle_pct = 0;
  int         stall_pct     = 0;
  int         hold_left     = 0;
  logic [7:0] size_txt[SIZE_LEN];

  tar_archive_entry_indexer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------- tracker
  function automatic logic [BLK_W-1:0] blocks_spanned(input logic [SIZE_W-1:0] sz);
    return BLK_W'((37'(sz) + 37'(BLOCK_BYTES - 1)) >> BIB_W);
  endfunction

  function automatic logic size_parsed_ok();
    return (pmode == PM_DIG_POS) || (pmode == PM_STOP_POS);
  endfunction

  task automatic expect_word(input logic [1:0] k, input logic [2:0] e,
                             input logic [SIZE_W-1:0] sz, input logic ln);
    out_word_t w;
    w.kind           = k;
    w.error_code     = e;
    w.data_offset    = offset;
    w.file_size      = sz;
    w.long_name_used = ln;
    entries_due.push_back(w);
  endtask

  task automatic expect_error(input logic [2:0] e);
    expect_word(KIND_ERROR, e, '0, 1'b0);
    ph = PH_DONE;
  endtask

  task automatic expect_entry(input logic ln);
    if (!size_parsed_ok()) begin
      expect_error(ERR_BAD_SIZE);
    end else begin
      blk_left = blocks_spanned(size_acc);
      if (blk_left != 0) ph = PH_SKIP;
      else ph = PH_HEADER;
      expect_word(KIND_ENTRY, ERR_NONE, size_acc, ln);
    end
  endtask

  task automatic parse_size_char(input logic [7:0] b);
    logic       oct;
    logic       ws;
    logic [2:0] d;
    oct = (b >= CH_ZERO) && (b <= CH_SEVEN);
    ws  = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    d   = b[2:0];
    case (pmode)
      PM_WS: begin
        if (!ws) begin
          if (b == CH_PLUS) pmode = PM_PLUS;
          else if (b == CH_MINUS) pmode = PM_MINUS;
          else if (oct) begin
            size_acc = SIZE_W'(d);
            pmode    = PM_DIG_POS;
          end else pmode = PM_STOP_NONE;
        end
      end
      PM_PLUS, PM_MINUS: begin
        if (oct) begin
          size_acc = SIZE_W'(d);
          if (pmode == PM_PLUS) pmode = PM_DIG_POS;
          else pmode = PM_DIG_NEG;
        end else pmode = PM_STOP_NONE;
      end
      PM_DIG_POS, PM_DIG_NEG: begin
        if (oct) size_acc = {size_acc[SIZE_W-4:0], d};
        else if (pmode == PM_DIG_POS) pmode = PM_STOP_POS;
        else pmode = PM_STOP_NEG;
      end
      default: ;
    endcase
  endtask

  task automatic track_word(input in_word_t w);
    logic last;
    if (ph == PH_DONE) return;
    if (w.func == FUNC_EOS) begin
      if (ph == PH_LONG_DATA) expect_error(ERR_LONG_CUT);
      else if (ph == PH_AFTER_LONG) expect_error(ERR_AFTER_LONG_CUT);
      else if (ph == PH_HEADER && pos != 0) expect_error(ERR_CUT_BLOCK);
      else expect_word(KIND_STREAM_END, ERR_NONE, '0, 1'b0);
      ph = PH_DONE;
      return;
    end
    offset = offset + 1'b1;
    if (ph == PH_HEADER || ph == PH_AFTER_LONG) begin
      if (pos == 0) begin
        blk_zero = 1'b1;
        size_acc = '0;
        pmode    = PM_WS;
      end
      if (w.data_byte != 8'h00) blk_zero = 1'b0;
      if (pos >= SIZE_FIRST && pos <= SIZE_LAST) parse_size_char(w.data_byte);
      if (pos == TYPE_POS) type_b = w.data_byte;
    end
    last = (pos == LAST_BYTE);
    pos  = pos + 1'b1;
    if (!last) return;
    case (ph)
      PH_HEADER: begin
        if (blk_zero) begin
          if (zero_seen) begin
            expect_word(KIND_ZERO_END, ERR_NONE, '0, 1'b0);
            ph = PH_DONE;
          end else zero_seen = 1'b1;
        end else begin
          zero_seen = 1'b0;
          if (type_b == LONG_NAME_TYPE) begin
            if (!size_parsed_ok() || size_acc == 0 || size_acc >= SIZE_W'(long_limit)) begin
              expect_error(ERR_BAD_LONG_SIZE);
            end else begin
              blk_left = blocks_spanned(size_acc);
              ph       = PH_LONG_DATA;
            end
          end else expect_entry(1'b0);
        end
      end
      PH_LONG_DATA: begin
        blk_left = blk_left - 1'b1;
        if (blk_left == 0) ph = PH_AFTER_LONG;
      end
      PH_AFTER_LONG: expect_entry(1'b1);
      PH_SKIP: begin
        blk_left = blk_left - 1'b1;
        if (blk_left == 0) ph = PH_HEADER;
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------- checking
  always @(posedge clk) begin : result_check
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (entries_due.size() == 0) begin
        $error("unexpected word: kind %0d error_code %0d", out_data.kind, out_data.error_code);
        mismatches++;
      end else begin
        want = entries_due.pop_front();
        if (out_data.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_data.kind);
          mismatches++;
        end
        if (out_data.error_code !== want.error_code) begin
          $error("error_code: expected %0d, got %0d", want.error_code, out_data.error_code);
          mismatches++;
        end
        if (out_data.data_offset !== want.data_offset) begin
          $error("data_offset: expected %0d, got %0d", want.data_offset, out_data.data_offset);
          mismatches++;
        end
        if (out_data.file_size !== want.file_size) begin
          $error("file_size: expected %0d, got %0d", want.file_size, out_data.file_size);
          mismatches++;
        end
        if (out_data.long_name_used !== want.long_name_used) begin
          $error("long_name_used: expected %0d, got %0d", want.long_name_used,
                 out_data.long_name_used);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // receiver: random stall, or a long hold-off while hold_left runs down
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------- driving
  task automatic offer_word(input logic f, input logic [7:0] b);
    in_word_t w;
    w.func      = f;
    w.data_byte = b;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    track_word(w);
  endtask

  task automatic sender_idle();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic await_idle();
    sender_idle();
    while (entries_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_idling(input int sender, input int receiver);
    send_idle_pct = sender;
    stall_pct     = receiver;
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] v);
    await_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    long_limit = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] plain_type();
    logic [7:0] t;
    do t = 8'($urandom); while (t == LONG_NAME_TYPE);
    return t;
  endfunction

  task automatic set_size_text(input string s);
    for (int i = 0; i < SIZE_LEN; i++) size_txt[i] = (i < s.len()) ? s[i] : 8'h00;
  endtask

  // octal text with random leading whitespace, plus sign, zero padding and stopper
  task automatic format_size(input logic [SIZE_W-1:0] v);
    int                k;
    int                pre;
    int                pad;
    int                p;
    logic [SIZE_W-1:0] t;
    k = 1;
    t = v >> 3;
    while (t != 0) begin
      k++;
      t = t >> 3;
    end
    pre = $urandom_range(0, (SIZE_LEN - k < 3) ? SIZE_LEN - k : 3);
    pad = $urandom_range(0, SIZE_LEN - k - pre);
    for (int i = 0; i < SIZE_LEN; i++) size_txt[i] = 8'($urandom);
    p = 0;
    repeat (pre) begin
      if (p == pre - 1 && $urandom_range(1) == 1) size_txt[p] = CH_PLUS;
      else if ($urandom_range(1) == 1) size_txt[p] = CH_SPACE;
      else size_txt[p] = CH_TAB + 8'($urandom_range(0, 4));
      p++;
    end
    repeat (pad) begin
      size_txt[p] = CH_ZERO;
      p++;
    end
    for (int j = k - 1; j >= 0; j--) begin
      size_txt[p] = CH_ZERO + 8'((v >> (3 * j)) & 7);
      p++;
    end
    if (p < SIZE_LEN) begin
      case ($urandom_range(3))
        0: size_txt[p] = 8'h00;
        1: size_txt[p] = CH_SPACE;
        2: size_txt[p] = CH_SEVEN + 8'($urandom_range(1, 2));
        default: begin
          size_txt[p] = 8'($urandom);
          if (size_txt[p] >= CH_ZERO && size_txt[p] <= CH_SEVEN) size_txt[p] = CH_MINUS;
        end
      endcase
    end
  endtask

  task automatic send_header(input logic [7:0] type_c, input int upto = BLOCK_BYTES);
    logic [7:0] b;
    for (int p = 0; p < upto; p++) begin
      if (p >= SIZE_FIRST && p <= SIZE_LAST) b = size_txt[p - SIZE_FIRST];
      else if (p == TYPE_POS) b = type_c;
      else b = ($urandom_range(1) == 1) ? 8'($urandom) : 8'h00;
      offer_word(FUNC_BYTE, b);
    end
  endtask

  task automatic send_zero_block();
    repeat (BLOCK_BYTES) offer_word(FUNC_BYTE, 8'h00);
  endtask

  task automatic send_data(input logic [SIZE_W-1:0] sz);
    repeat (int'(blocks_spanned(sz)) * BLOCK_BYTES) offer_word(FUNC_BYTE, 8'($urandom));
  endtask

  task automatic send_long_name(input int n);
    format_size(SIZE_W'(n));
    send_header(LONG_NAME_TYPE);
    send_data(SIZE_W'(n));
  endtask

  task automatic send_entry(input logic [SIZE_W-1:0] sz, input logic [7:0] type_c);
    format_size(sz);
    send_header(type_c);
    send_data(sz);
  endtask

  task automatic send_random_entry();
    logic [SIZE_W-1:0] sz;
    int                cap;
    case ($urandom_range(9))
      0: sz = '0;
      1: sz = SIZE_W'($urandom_range(1, 4) * BLOCK_BYTES);
      default: sz = SIZE_W'($urandom_range(1, 1500));
    endcase
    if ($urandom_range(11) == 0) send_zero_block();
    if (long_limit >= 2 && $urandom_range(4) == 0) begin
      cap = (long_limit - 1 < 1200) ? long_limit - 1 : 1200;
      send_long_name($urandom_range(1, cap));
      send_entry(sz, ($urandom_range(7) == 0) ? LONG_NAME_TYPE : plain_type());
    end else begin
      send_entry(sz, plain_type());
    end
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_header_forms();
    set_idling(0, 0);
    set_size_text("0");
    send_header(plain_type());
    set_size_text("\t\n  \r +17");
    size_txt[2] = 8'h0B;
    size_txt[3] = 8'h0C;
    send_header(plain_type());
    send_data(15);
    set_size_text("000000001000");
    send_header(plain_type());
    send_data(512);
    set_size_text("12389");
    send_header(plain_type());
    send_data(83);
    set_size_text("7");
    send_header(8'h00);
    send_data(7);
    // a lone zero block is skipped, a real header clears the count
    send_zero_block();
    send_entry('0, plain_type());
    send_zero_block();
    send_entry(600, plain_type());
  endtask

  task automatic test_long_names();
    set_idling(16, 16);
    send_long_name(1);
    set_size_text("+000");
    send_header(LONG_NAME_TYPE);
    send_long_name(512);
    send_entry(1, plain_type());
    send_long_name(513);
    send_entry(1024, plain_type());
    write_limit(16'd600);
    send_long_name(599);
    send_entry(40, plain_type());
    write_limit(16'hFFFF);
    send_long_name(65534);
    send_entry(3, plain_type());
  endtask

  task automatic test_output_backpressure();
    set_idling(0, 0);
    sender_idle();
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    repeat (8) send_entry('0, plain_type());
    await_idle();
  endtask

  task automatic test_random_archive();
    write_limit(16'hFFFF);
    set_idling(0, 0);
    repeat (12) send_random_entry();
    write_limit(16'd1);
    set_idling(84, 0);
    repeat (12) send_random_entry();
    write_limit(CFG_W'($urandom_range(2, 65535)));
    set_idling(0, 84);
    repeat (12) send_random_entry();
    write_limit(MAX_LONG_RESET);
    set_idling(16, 16);
    repeat (12) send_random_entry();
  endtask

  task automatic test_archive_end();
    end_case_t how;
    int        n;
    how = end_case_t'($urandom_range(0, 7));
    case (how)
      END_TWO_ZERO: begin
        send_zero_block();
        send_zero_block();
      end
      END_AT_BOUNDARY: offer_word(FUNC_EOS, 8'($urandom));
      END_IN_DATA: begin
        set_size_text("777777777777");
        send_header(plain_type());
        repeat ($urandom_range(0, 1500)) offer_word(FUNC_BYTE, 8'($urandom));
        offer_word(FUNC_EOS, 8'($urandom));
      end
      END_BAD_LONG: begin
        case ($urandom_range(4))
          0: set_size_text("-5");
          1: set_size_text(" x1");
          2: format_size('0);
          3: format_size(SIZE_W'(long_limit));
          default: begin
            write_limit('0);
            format_size(5);
          end
        endcase
        send_header(LONG_NAME_TYPE);
      end
      END_LONG_CUT: begin
        n = $urandom_range(1, 1000);
        format_size(SIZE_W'(n));
        send_header(LONG_NAME_TYPE);
        repeat ($urandom_range(0, int'(blocks_spanned(SIZE_W'(n))) * BLOCK_BYTES - 1))
          offer_word(FUNC_BYTE, 8'($urandom));
        offer_word(FUNC_EOS, 8'($urandom));
      end
      END_AFTER_LONG_CUT: begin
        send_long_name($urandom_range(1, 1000));
        format_size(SIZE_W'($urandom_range(0, 1000)));
        send_header(plain_type(), $urandom_range(0, BLOCK_BYTES - 1));
        offer_word(FUNC_EOS, 8'($urandom));
      end
      END_BAD_SIZE: begin
        case ($urandom_range(3))
          0: begin
            set_size_text("-17");
            send_header(plain_type());
          end
          1: begin
            set_size_text("");
            send_header(plain_type());
          end
          2: begin
            set_size_text("+x");
            send_header(plain_type());
          end
          default: begin
            send_long_name(3);
            if ($urandom_range(1) == 1) begin
              send_zero_block();
            end else begin
              set_size_text("-3");
              send_header(plain_type());
            end
          end
        endcase
      end
      default: begin
        format_size(SIZE_W'($urandom_range(0, 1000)));
        send_header(plain_type(), $urandom_range(1, BLOCK_BYTES - 1));
        offer_word(FUNC_EOS, 8'($urandom));
      end
    endcase
    // everything after the end is taken and dropped
    repeat (40) offer_word(1'($urandom_range(1)), 8'($urandom));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_header_forms();
    test_long_names();
    test_output_backpressure();
    test_random_archive();
    test_archive_end();
    await_idle();
    repeat (8) @(posedge clk);
    if (entries_due.size() != 0) $error("%0d expected words never came", entries_due.size());
    if (mismatches == 0 && entries_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
